// File: sv/case_insensitive_marker_detector_assert.svh
// assertion helpers for the marker detector
// all checks are clocked on clk and held off while rst_n is low
`ifndef CASE_INSENSITIVE_MARKER_DETECTOR_ASSERT_SVH
`define CASE_INSENSITIVE_MARKER_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define CIMD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CIMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CIMD_ASSERT_SAME(lbl, ante, cons)
`define CIMD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/cimd_pkg.sv
`timescale 1ns / 1ps
package cimd_pkg;

  localparam int MAX_PATTERN_LEN = 36;
  localparam int NUM_CELLS       = MAX_PATTERN_LEN - 1;
  localparam int PAT_W           = MAX_PATTERN_LEN * 8;
  localparam int NUM_PAT         = 51;

  typedef enum logic [1:0] {
    SET_KEY   = 2'd0,
    SET_VALUE = 2'd1,
    SET_XMP   = 2'd2
  } pset_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cimd_ctrl_t;

  // marker text, right aligned, zero padded on the left
  localparam logic [PAT_W-1:0] PAT_TEXT [NUM_PAT] = '{
    // key names
    PAT_W'("parameters"),
    PAT_W'("prompt"),
    PAT_W'("negative prompt"),
    PAT_W'({"negative", "_prompt"}),
    PAT_W'("sd-metadata"),
    PAT_W'("dream"),
    PAT_W'("extras"),
    PAT_W'("comment"),
    PAT_W'("software"),
    PAT_W'("usercomment"),
    PAT_W'("ai"),
    PAT_W'("generative"),
    PAT_W'({"invoke", "ai"}),
    PAT_W'({"comfy", "ui"}),
    PAT_W'({"automatic", "1111"}),
    PAT_W'({"stable ", "diffusion"}),
    // value markers
    PAT_W'("steps:"),
    PAT_W'("sampler:"),
    PAT_W'("cfg scale:"),
    PAT_W'("seed:"),
    PAT_W'("model hash:"),
    PAT_W'("model:"),
    PAT_W'("negative prompt:"),
    PAT_W'("clip skip:"),
    PAT_W'("denoising strength:"),
    PAT_W'({"stable ", "diffusion"}),
    PAT_W'({"dall", "-e"}),
    PAT_W'({"dall", 8'hc2, 8'hb7, "e"}),
    PAT_W'({"mid", "journey"}),
    PAT_W'({"fire", "fly"}),
    PAT_W'({"crai", "yon"}),
    PAT_W'({"novel", "ai"}),
    PAT_W'({"comfy", "ui"}),
    PAT_W'({"invoke", "ai"}),
    PAT_W'({"automatic", "1111"}),
    PAT_W'({"a1", "111"}),
    PAT_W'({"sd", "xl"}),
    PAT_W'({"fl", "ux"}),
    // xmp markers
    PAT_W'({"photo", "shop:credit"}),
    PAT_W'("xmp:creatortool"),
    PAT_W'("generative"),
    PAT_W'({"fire", "fly"}),
    PAT_W'("dall"),
    PAT_W'({"mid", "journey"}),
    PAT_W'({"stable ", "diffusion"}),
    PAT_W'({"open", "ai"}),
    PAT_W'("c2pa"),
    PAT_W'({"claim", "_generator"}),
    PAT_W'("digitalsourcetype"),
    PAT_W'("trainedalgorithmicmedia"),
    PAT_W'("compositewithtrainedalgorithmicmedia")
  };

  localparam pset_t PAT_SET [NUM_PAT] = '{
    SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY,
    SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY, SET_KEY,
    SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE,
    SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE,
    SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE,
    SET_VALUE, SET_VALUE, SET_VALUE, SET_VALUE,
    SET_XMP, SET_XMP, SET_XMP, SET_XMP, SET_XMP, SET_XMP, SET_XMP,
    SET_XMP, SET_XMP, SET_XMP, SET_XMP, SET_XMP, SET_XMP
  };

  // marker length: markers hold no zero byte, so count up to the top nonzero byte
  function automatic int pat_len(input int p);
    int len;
    len = 0;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      if (PAT_TEXT[p][i*8 +: 8] != 8'h00) begin
        len = i + 1;
      end
    end
    return len;
  endfunction

  // character k of marker p, counted from its first character
  function automatic logic [7:0] pat_char(input int p, input int k);
    int len;
    len = pat_len(p);
    return PAT_TEXT[p][(len - 1 - k)*8 +: 8];
  endfunction

endpackage

// File: sv/cimd_if.sv
`timescale 1ns / 1ps
interface cimd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface cimd_out_if;
  logic valid;
  logic ready;
  logic looks_generated;

  modport source (output valid, output looks_generated, input ready);
  modport sink   (input valid, input looks_generated, output ready);
endinterface

// File: sv/cimd_decode.sv
`timescale 1ns / 1ps
module cimd_decode
  import cimd_pkg::*;
(
  input  logic [7:0]                             text_byte,
  output logic [MAX_PATTERN_LEN-1:0][NUM_PAT-1:0] char_eq
);

  logic [7:0] folded;

  // ascii upper case to lower case only
  always_comb begin
    folded = text_byte;
    if (text_byte >= 8'h41 && text_byte <= 8'h5a) begin
      folded = text_byte + 8'h20;
    end
  end

  for (genvar p = 0; p < NUM_PAT; p++) begin : g_pat
    for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_pos
      if (k < pat_len(p)) begin : g_cmp
        localparam logic [7:0] CH = pat_char(p, k);
        assign char_eq[k][p] = (folded == CH);
      end else begin : g_none
        assign char_eq[k][p] = 1'b0;
      end
    end
  end

endmodule

// File: sv/cimd_cell.sv
`timescale 1ns / 1ps
module cimd_cell
  import cimd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cimd_ctrl_t         ctrl,
  input  logic [NUM_PAT-1:0] prefix_in,
  input  logic [NUM_PAT-1:0] char_eq,
  output logic [NUM_PAT-1:0] prefix_out
);

  // bit p: the newest bytes match the first (cell position + 1) chars of marker p
  logic [NUM_PAT-1:0] prefix_r;
  logic [NUM_PAT-1:0] prefix_nxt;

  always_comb begin
    prefix_nxt = prefix_r;
    if (ctrl.clear) begin
      prefix_nxt = '0;
    end else if (ctrl.shift) begin
      prefix_nxt = prefix_in & char_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
    end else begin
      prefix_r <= prefix_nxt;
    end
  end

  assign prefix_out = prefix_r;

endmodule

// File: sv/case_insensitive_marker_detector.sv
`timescale 1ns / 1ps
// channel | dir | fields                  | handshake
// in_ch   | in  | text_byte, last_byte    | valid / ready
// out_ch  | out | looks_generated         | valid / ready
// cfg     | in  | cfg_wr_data (set)       | cfg_wr_en, no wait
//
// one byte request per cycle while in_ch.ready is high; the match for a byte is
// decided in the cycle it is taken, the result sits in the output register in the
// cycle after the last byte; each prefix cell shifts once per accepted live byte
// synchronous active-low reset clears cells, flags, output valid, set = value
// in_ch.ready drops only while a finished result waits and out_ch.ready is low
module case_insensitive_marker_detector
  import cimd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  cimd_in_if.sink           in_ch,
  cimd_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data
);

`include "case_insensitive_marker_detector_assert.svh"

  // selected marker set, 3 selects nothing
  logic [1:0] cfg_r;
  logic [1:0] cfg_nxt;

  // per-string sticky flags
  logic hit_r;
  logic hit_nxt;
  logic term_r;
  logic term_nxt;

  // single-entry output slot
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_gen_r;
  logic out_gen_nxt;

  logic       accept;
  logic       is_zero;
  logic       hit_now;
  cimd_ctrl_t ctrl;

  logic [MAX_PATTERN_LEN-1:0][NUM_PAT-1:0] char_eq;
  logic [NUM_CELLS-1:0][NUM_PAT-1:0]       prefix;
  logic [NUM_PAT-1:0]                      end_match;
  logic [NUM_PAT-1:0]                      set_mask;

  // free the input side whenever the slot empties this cycle or is empty
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_zero     = (in_ch.text_byte == 8'h00);

  // live bytes shift the cells; a zero byte freezes them for the rest of the string
  assign ctrl.shift = accept && !term_r && !is_zero;
  assign ctrl.clear = accept && in_ch.last_byte;

  // byte against every marker position
  cimd_decode u_decode (
    .text_byte (in_ch.text_byte),
    .char_eq   (char_eq)
  );

  // row of prefix cells; the first one starts every marker
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic [NUM_PAT-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = '1;
    end else begin : g_link
      assign prev = prefix[k-1];
    end
    cimd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prefix_in  (prev),
      .char_eq    (char_eq[k]),
      .prefix_out (prefix[k])
    );
  end

  // full marker ends at the current byte: prefix of length-1 plus its last char
  for (genvar p = 0; p < NUM_PAT; p++) begin : g_end
    localparam int LEN = pat_len(p);
    if (LEN >= 2 && LEN <= MAX_PATTERN_LEN) begin : g_long
      assign end_match[p] = prefix[LEN-2][p] && char_eq[LEN-1][p];
    end else if (LEN == 1) begin : g_one
      assign end_match[p] = char_eq[0][p];
    end else begin : g_never
      assign end_match[p] = 1'b0;
    end
    assign set_mask[p] = (cfg_r == PAT_SET[p]);
  end

  assign hit_now = ctrl.shift && |(end_match & set_mask);

  always_comb begin
    cfg_nxt       = cfg_r;
    hit_nxt       = hit_r || hit_now;
    term_nxt      = term_r || (accept && is_zero);
    out_valid_nxt = out_valid_r;
    out_gen_nxt   = out_gen_r;

    if (cfg_wr_en) begin
      cfg_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // last byte: report and start the next string clean
    if (ctrl.clear) begin
      out_valid_nxt = 1'b1;
      out_gen_nxt   = hit_r || hit_now;
      hit_nxt       = 1'b0;
      term_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= SET_VALUE;
      hit_r       <= 1'b0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      hit_r       <= hit_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_gen_r <= out_gen_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.looks_generated = out_gen_r;

  `CIMD_ASSERT_NEXT(a_last_gives_result, accept && in_ch.last_byte, out_valid_r)
  `CIMD_ASSERT_NEXT(a_last_clears_string, accept && in_ch.last_byte, prefix[0] == '0 && !hit_r && !term_r)
  `CIMD_ASSERT_NEXT(a_zero_ends_matching, accept && is_zero && !in_ch.last_byte, term_r)
  `CIMD_ASSERT_NEXT(a_slot_drains, out_valid_r && out_ch.ready && !accept, !out_valid_r)

endmodule
